// ===== sv/chm_pkg.sv =====
// Shared types and constants for the CAN heartbeat monitor.
`default_nettype none

package chm_pkg;

  // Field widths fixed by the word formats
  localparam int IDENT_W = 29;
  localparam int TMO_W   = 31;
  localparam int FLAG_W  = 4;
  localparam int MAX_NODES = 4;

  // Configuration register index
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_BEAT_TIMEOUT = 3'd0;
  localparam cfg_idx_t REG_STATUS_HOLD  = 3'd1;
  localparam cfg_idx_t REG_NODE0_IDENT  = 3'd2;

  // Register reset values
  localparam logic [TMO_W-1:0]   BEAT_TIMEOUT_RST = 31'd100;
  localparam logic [TMO_W-1:0]   STATUS_HOLD_RST  = 31'd2000;
  localparam logic [IDENT_W-1:0] NODE0_IDENT_RST  = 29'h101;

  // Request kinds and bus codes
  localparam logic     REQ_TICK    = 1'b0;
  localparam logic     REQ_FRAME   = 1'b1;
  localparam logic [1:0] BUS_UNKNOWN = 2'd3;

  // Fixed command identifiers
  localparam logic [IDENT_W-1:0] ID_EV0_SET = 29'h105;
  localparam logic [IDENT_W-1:0] ID_EV0_CLR = 29'h106;
  localparam logic [IDENT_W-1:0] ID_EV1_SET = 29'h107;
  localparam logic [IDENT_W-1:0] ID_EV1_CLR = 29'h108;
  localparam logic [IDENT_W-1:0] ID_EV2_SW  = 29'h109;
  localparam logic [IDENT_W-1:0] ID_EV3_SW  = 29'h10A;

  // Events cleared once the status hold has run out
  localparam logic [FLAG_W-1:0] EV_HOLD_MASK = 4'b1100;

  // Input word
  typedef struct packed {
    logic               req_type;
    logic [1:0]         bus_index;
    logic [IDENT_W-1:0] frame_ident;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [FLAG_W-1:0] lost_flags;
    logic [FLAG_W-1:0] event_flags;
  } out_word_t;

  // Decoded frame actions
  typedef struct packed {
    logic [MAX_NODES-1:0] node_hit;
    logic [FLAG_W-1:0]    ev_set;
    logic [FLAG_W-1:0]    ev_clr;
    logic                 stamp_switch;
  } frame_dec_t;

endpackage

`default_nettype wire

// ===== sv/chm_frame_dec.sv =====
// Identifier matcher: node heartbeat identifiers first, then fixed command identifiers.
`default_nettype none

module chm_frame_dec #(
  parameter int NODE_COUNT = 4
) (
  input  wire logic [NODE_COUNT-1:0][chm_pkg::IDENT_W-1:0] node_ident,
  input  wire logic [chm_pkg::IDENT_W-1:0]                 frame_ident,
  output chm_pkg::frame_dec_t                              dec
);

  logic [chm_pkg::MAX_NODES-1:0] hit;
  logic                          found;

  // Pick the lowest-numbered node whose identifier matches
  always_comb begin
    hit   = '0;
    found = 1'b0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (!found && (node_ident[i] == frame_ident)) begin
        hit[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  // Fall back to the command identifiers when no node claims the frame
  always_comb begin
    dec              = '0;
    dec.node_hit     = hit;
    if (!found) begin
      case (frame_ident)
        chm_pkg::ID_EV0_SET: dec.ev_set = 4'b0001;
        chm_pkg::ID_EV0_CLR: dec.ev_clr = 4'b0001;
        chm_pkg::ID_EV1_SET: dec.ev_set = 4'b0010;
        chm_pkg::ID_EV1_CLR: dec.ev_clr = 4'b0010;
        chm_pkg::ID_EV2_SW: begin
          dec.ev_set       = 4'b0100;
          dec.stamp_switch = 1'b1;
        end
        chm_pkg::ID_EV3_SW: begin
          dec.ev_set       = 4'b1000;
          dec.stamp_switch = 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/can_heartbeat_monitor.sv =====
// Top level of the CAN heartbeat monitor: input register, update logic, result register.
//
// Takes one word per clock while in_stall is low and returns one result word per input
// word, in order. A word is held in the input register and then processed into the
// result register, which offers its result and holds it while the output is stalled.
// The clock rate is limited by one subtract-and-compare per node against the timeout,
// plus the identifier match, all combinational between the input and result registers.
// A tick word advances the time counter and refreshes the lost and hold-expired flags;
// a frame word from bus 0 to 2 stamps a node's heartbeat time or applies a command.
// Frames on bus 3 change nothing. Configuration may be written only while no word is
// in flight.
`default_nettype none

module can_heartbeat_monitor #(
  parameter int NODE_COUNT = 4,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire chm_pkg::in_word_t         in_data,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output chm_pkg::out_word_t             out_data,
  // configuration
  input  wire logic                      cfg_we,
  input  wire chm_pkg::cfg_idx_t         cfg_index,
  input  wire logic [chm_pkg::TMO_W-1:0] cfg_wdata
);

  localparam int CMP_W = (TIME_WIDTH > chm_pkg::TMO_W) ? TIME_WIDTH : chm_pkg::TMO_W;

  // Configuration registers
  logic [chm_pkg::TMO_W-1:0]                        beat_timeout_r;
  logic [chm_pkg::TMO_W-1:0]                        status_hold_r;
  logic [NODE_COUNT-1:0][chm_pkg::IDENT_W-1:0]      node_ident_r;

  // Pipeline registers
  logic                s1_valid_r;
  chm_pkg::in_word_t   s1_word_r;
  logic                out_valid_r;
  chm_pkg::out_word_t  out_word_r;

  // Monitor state
  logic [TIME_WIDTH-1:0]                  time_r;
  logic [TIME_WIDTH-1:0]                  time_nxt;
  logic [NODE_COUNT-1:0][TIME_WIDTH-1:0]  last_beat_r;
  logic [TIME_WIDTH-1:0]                  last_switch_r;
  logic [chm_pkg::FLAG_W-1:0]             lost_r;
  logic [chm_pkg::FLAG_W-1:0]             lost_nxt;
  logic [chm_pkg::FLAG_W-1:0]             event_r;
  logic [chm_pkg::FLAG_W-1:0]             event_nxt;

  logic                 s1_fire;
  logic                 is_tick;
  logic                 is_frame;
  logic [TIME_WIDTH-1:0] time_inc;
  logic [chm_pkg::FLAG_W-1:0] lost_tick;
  logic [TIME_WIDTH-1:0] switch_age;
  logic                 hold_expired;
  chm_pkg::frame_dec_t  dec;

  // Handshake: advance the input register whenever the result register is free
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign is_tick  = (s1_word_r.req_type == chm_pkg::REQ_TICK);
  assign is_frame = (s1_word_r.req_type == chm_pkg::REQ_FRAME) &&
                    (s1_word_r.bus_index != chm_pkg::BUS_UNKNOWN);
  assign time_inc = time_r + TIME_WIDTH'(1);

  // Match the frame identifier
  chm_frame_dec #(
    .NODE_COUNT (NODE_COUNT)
  ) u_frame_dec (
    .node_ident  (node_ident_r),
    .frame_ident (s1_word_r.frame_ident),
    .dec         (dec)
  );

  // Per-node timeout check against the advanced time, and heartbeat stamp
  for (genvar g = 0; g < chm_pkg::MAX_NODES; g++) begin : g_node
    if (g < NODE_COUNT) begin : g_used
      logic [TIME_WIDTH-1:0] beat_age;
      assign beat_age     = time_inc - last_beat_r[g];
      assign lost_tick[g] = CMP_W'(beat_age) > CMP_W'(beat_timeout_r);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          last_beat_r[g]  <= '0;
          node_ident_r[g] <= chm_pkg::NODE0_IDENT_RST + chm_pkg::IDENT_W'(g);
        end else begin
          if (s1_fire && is_frame && dec.node_hit[g]) begin
            last_beat_r[g] <= time_r;
          end
          if (cfg_we && (cfg_index == chm_pkg::cfg_idx_t'(chm_pkg::REG_NODE0_IDENT + g))) begin
            node_ident_r[g] <= cfg_wdata[chm_pkg::IDENT_W-1:0];
          end
        end
      end
    end else begin : g_unused
      assign lost_tick[g] = 1'b0;
    end
  end

  assign switch_age   = time_inc - last_switch_r;
  assign hold_expired = CMP_W'(switch_age) > CMP_W'(status_hold_r);

  // Next flags and time
  always_comb begin
    time_nxt  = time_r;
    lost_nxt  = lost_r;
    event_nxt = event_r;
    if (is_tick) begin
      time_nxt = time_inc;
      lost_nxt = lost_tick;
      if (hold_expired) begin
        event_nxt = event_r & ~chm_pkg::EV_HOLD_MASK;
      end
    end else if (is_frame) begin
      event_nxt = (event_r | dec.ev_set) & ~dec.ev_clr;
    end
  end

  // Hold the monitor state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r         <= '0;
      last_switch_r  <= '0;
      lost_r         <= '0;
      event_r        <= '0;
      beat_timeout_r <= chm_pkg::BEAT_TIMEOUT_RST;
      status_hold_r  <= chm_pkg::STATUS_HOLD_RST;
    end else begin
      if (s1_fire) begin
        time_r  <= time_nxt;
        lost_r  <= lost_nxt;
        event_r <= event_nxt;
        if (is_frame && dec.stamp_switch) begin
          last_switch_r <= time_r;
        end
      end
      if (cfg_we && (cfg_index == chm_pkg::REG_BEAT_TIMEOUT)) begin
        beat_timeout_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == chm_pkg::REG_STATUS_HOLD)) begin
        status_hold_r <= cfg_wdata;
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r <= in_data;
    end
    if (s1_fire) begin
      out_word_r.lost_flags  <= lost_nxt;
      out_word_r.event_flags <= event_nxt;
    end
  end

  // Checks
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_tick) |=> (time_r == $past(time_r) + TIME_WIDTH'(1)))
    else $error("tick did not advance time by one");

  a_frame_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !is_tick) |=> ($stable(time_r) && $stable(lost_r)))
    else $error("frame changed time or lost flags");

  a_unknown_bus_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !is_tick && !is_frame) |=> ($stable(event_r) && $stable(last_switch_r)))
    else $error("frame on unknown bus changed state");

  a_unused_nodes_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_word_r.lost_flags & ~lost_tick) == '0 || !is_tick ||
                     ((out_word_r.lost_flags >> NODE_COUNT) == '0)))
    else $error("lost flag set for an unused node");

endmodule

`default_nettype wire
